>>> hdl/gcdist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcdist_pkg
// Shared types, fixed-point constants and elaboration-time table functions
// for the great circle distance core.
// ----------------------------------------------------------------------------
package gcdist_pkg;

   localparam int ANGLE_FRAC_BITS = 30;

   // field widths
   localparam int LAT_W      = 28;
   localparam int LON_W      = 29;
   localparam int RADIUS_W   = 14;
   localparam int ANGLE_W    = 32;
   localparam int KM_W       = 26;
   localparam int MI_W       = 25;
   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 88;

   // tdata field offsets
   localparam int LAT1_LSB = 0;
   localparam int LON1_LSB = LAT1_LSB + LAT_W;
   localparam int LAT2_LSB = LON1_LSB + LON_W;
   localparam int LON2_LSB = LAT2_LSB + LAT_W;
   localparam int KM_LSB   = ANGLE_W;
   localparam int MI_LSB   = KM_LSB + KM_W;
   localparam int RSP_PAD  = RSP_DATA_W - MI_LSB - MI_W;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 14'd6371;

   // internal datapath widths
   localparam int MAG_W      = 28;
   localparam int ROT_W      = 34;
   localparam int VEC_W      = 60;
   localparam int ZV_W       = 34;
   localparam int SQ_W       = 64;
   localparam int ROOT_W     = 32;
   localparam int SQRT_STEPS = 32;
   localparam int VEC_SHIFT  = 24;

   // angles in half-microdegrees
   localparam logic signed [31:0] FULL_TURN    = 32'sd720000000;
   localparam logic signed [31:0] HALF_TURN    = 32'sd360000000;
   localparam logic signed [31:0] QUARTER_TURN = 32'sd180000000;

   localparam logic [63:0] DEG_DIVISOR = 64'd114591559;
   localparam logic [63:0] PI_Q62      = 64'hC90FDAA22168C234;
   localparam logic [63:0] PI_FIX_W    = PI_Q62 >> (62 - ANGLE_FRAC_BITS);
   localparam logic [ANGLE_W-1:0] PI_FIX = PI_FIX_W[ANGLE_W-1:0];

   // half-microdegrees to radians: |h| * CONV >> CONV_SHIFT
   localparam logic [63:0] CONV_Q = (64'd1 << 63) / DEG_DIVISOR;
   localparam logic [63:0] CONV_R = (64'd1 << 63) % DEG_DIVISOR;
   localparam logic [63:0] CONV   = (CONV_Q << 24) | ((CONV_R << 24) / DEG_DIVISOR);
   localparam int CONV_SHIFT = 87 - ANGLE_FRAC_BITS;
   localparam logic [31:0] CONV_LO = CONV[31:0];
   localparam logic [28:0] CONV_HI = CONV[60:32];

   typedef struct packed {
      logic signed [ROT_W-1:0] x;
      logic signed [ROT_W-1:0] y;
      logic signed [ROT_W-1:0] z;
   } rot_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ZV_W-1:0]  z;
   } vec_type;

   typedef struct packed {
      logic [SQ_W-1:0]   rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic             msign;
      logic             neg;
   } red_type;

   function automatic logic [63:0] rnd_shr64(input logic [63:0] v, input int s);
      logic [63:0] r;
      if (s == 0) r = v;
      else r = (v >> s) + ((v >> (s - 1)) & 64'd1);
      return r;
   endfunction

   // shift-subtract divide, elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(2^-step) in Q.F; series in Q62 for step > 0
   function automatic logic [63:0] atan_q(input int step);
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] res;
      int          e;
      sum = '0;
      if (step == 0) begin
         res = rnd_shr64(PI_Q62, 64 - ANGLE_FRAC_BITS);
      end else begin
         for (int k = 0; k < 32; k++) begin
            e = step * (2 * k + 1);
            if (e <= 62) begin
               term = udiv64((64'd1 << 62) >> e, 64'(2 * k + 1));
               if (k % 2 == 1) sum = sum - term;
               else sum = sum + term;
            end
         end
         res = rnd_shr64(sum, 62 - ANGLE_FRAC_BITS);
      end
      return res;
   endfunction

   // 1/prod(1+4^-i) in Q62
   function automatic logic [63:0] inv_gain_sq(input int steps);
      logic [63:0] p;
      p = 64'd1 << 62;
      for (int i = 0; i < 64; i++) begin
         if (i < steps && 2 * i < 62) p = p - udiv64(p, (64'd1 << (2 * i)) + 64'd1);
      end
      return p;
   endfunction

   // |h| < 2^29 stays inside one full turn, so only one wrap step is needed
   function automatic red_type reduce_angle(input logic signed [31:0] h);
      logic signed [31:0] m;
      red_type            r;
      m     = h;
      r.neg = 1'b0;
      if (m >= HALF_TURN) m = m - FULL_TURN;
      if (m < -HALF_TURN) m = m + FULL_TURN;
      if (m > QUARTER_TURN) begin
         m     = m - HALF_TURN;
         r.neg = 1'b1;
      end
      if (m < -QUARTER_TURN) begin
         m     = m + HALF_TURN;
         r.neg = 1'b1;
      end
      r.msign = m[31];
      r.mag   = m[31] ? MAG_W'(-m) : MAG_W'(m);
      return r;
   endfunction

endpackage

>>> hdl/gcdist_rot_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcdist_rot_cell
// One rotation-mode CORDIC step with its output register.
// ----------------------------------------------------------------------------
module gcdist_rot_cell #(
   parameter int STEP = 0
) (
   input  logic                 clock,
   input  logic                 en,
   input  gcdist_pkg::rot_type  din,
   output gcdist_pkg::rot_type  dout
);
   import gcdist_pkg::*;

   localparam logic [63:0] ATN_W = atan_q(STEP);
   localparam logic signed [ROT_W-1:0] ATN = ATN_W[ROT_W-1:0];

   rot_type                 step_ff, step_in;
   logic signed [ROT_W-1:0] dx, dy;

   always_comb begin
      dx      = din.y >>> STEP;
      dy      = din.x >>> STEP;
      step_in = din;
      if (din.z >= 0) begin
         step_in.x = din.x - dx;
         step_in.y = din.y + dy;
         step_in.z = din.z - ATN;
      end else begin
         step_in.x = din.x + dx;
         step_in.y = din.y - dy;
         step_in.z = din.z + ATN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) step_ff <= step_in;
   end

   assign dout = step_ff;

endmodule

>>> hdl/gcdist_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcdist_sqrt_cell
// One result bit of a restoring floor square root, registered.
// ----------------------------------------------------------------------------
module gcdist_sqrt_cell #(
   parameter int BIT = 0
) (
   input  logic                 clock,
   input  logic                 en,
   input  gcdist_pkg::sqrt_type din,
   output gcdist_pkg::sqrt_type dout
);
   import gcdist_pkg::*;

   localparam int TW = SQ_W + 2;

   sqrt_type        bit_ff, bit_in;
   logic [TW-1:0]   trial;

   // (r + 2^k)^2 - r^2 with the low k bits of r still clear
   always_comb begin
      trial  = (TW'(din.root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
      bit_in = din;
      if ({2'b00, din.rem} >= trial) begin
         bit_in.rem       = din.rem - trial[SQ_W-1:0];
         bit_in.root[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) bit_ff <= bit_in;
   end

   assign dout = bit_ff;

endmodule

>>> hdl/gcdist_vec_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcdist_vec_cell
// One vectoring-mode CORDIC step with its output register.
// ----------------------------------------------------------------------------
module gcdist_vec_cell #(
   parameter int STEP = 0
) (
   input  logic                 clock,
   input  logic                 en,
   input  gcdist_pkg::vec_type  din,
   output gcdist_pkg::vec_type  dout
);
   import gcdist_pkg::*;

   localparam logic [63:0] ATN_W = atan_q(STEP);
   localparam logic signed [ZV_W-1:0] ATN = ATN_W[ZV_W-1:0];

   vec_type                 step_ff, step_in;
   logic signed [VEC_W-1:0] dx, dy;

   // drive y toward zero, clockwise while y is not negative
   always_comb begin
      dx      = din.y >>> STEP;
      dy      = din.x >>> STEP;
      step_in = din;
      if (din.y >= 0) begin
         step_in.x = din.x + dx;
         step_in.y = din.y - dy;
         step_in.z = din.z + ATN;
      end else begin
         step_in.x = din.x - dx;
         step_in.y = din.y + dy;
         step_in.z = din.z - ATN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) step_ff <= step_in;
   end

   assign dout = step_ff;

endmodule

>>> hdl/great_circle_distance_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_distance_core
// Haversine distance between two positions, fully pipelined: angle reduction,
// rotation CORDIC, fixed-point products, square roots and vectoring CORDIC.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake           Payload (low bits first)
//  req_     in   req_tvalid/tready   lat1[28], lon1[29], lat2[28], lon2[29]
//  rsp_     out  rsp_tvalid/tready   angle[32] Q2.30, km[26], miles[25] (1/1024)
//  csr_     in   csr_wr_en           earth radius, whole km
//
//  One transfer per cycle in each direction when the sink keeps up.
//  Latency is set by the two CORDIC cell chains
//  and the 32-cell square-root chain.
//  Reset clears the stage valid bits, the output/skid flags and sets the
//  radius to 6371 km.
//  A stall on rsp_ fills a one-entry skid register first; only once that is
//  full does the whole pipeline freeze and req_tready drop.
//
module great_circle_distance_core #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // lat1 [27:0], lon1 [56:28], lat2 [84:57], lon2 [113:85], zero pad
   input  logic [gcdist_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // central_angle [31:0], distance_kilometers [57:32],
   // distance_miles [82:58], zero pad
   output logic [gcdist_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [gcdist_pkg::RADIUS_W-1:0]     csr_wr_data
);
   import gcdist_pkg::*;

   localparam int N   = CORDIC_STEPS;
   localparam int LAT = 44 + 2 * N;   // pipeline stages ahead of output reg

   localparam logic [63:0] INV_GAIN = inv_gain_sq(N);
   localparam logic [30:0] INV_LO   = INV_GAIN[30:0];
   localparam logic [29:0] INV_HI   = INV_GAIN[60:31];

   localparam logic signed [ROT_W-1:0] ROT_ONE = ROT_W'(64'd1 << ANGLE_FRAC_BITS);
   localparam logic [30:0] A_ONE = 31'(64'd1 << ANGLE_FRAC_BITS);

   localparam int PW = 2 * ROT_W;     // product widths
   localparam int TW = 96;

   // ---------------------------------------------------------------- control
   logic             pipe_en;
   logic [LAT-1:0]   vld_ff;
   logic             out_v_ff, out_v_in, skid_v_ff, skid_v_in;
   logic [RSP_DATA_W-1:0] out_ff, out_in, skid_ff, skid_in, pipe_data;
   logic             pipe_out_v;

   logic [RADIUS_W-1:0] radius_ff;

   assign pipe_en    = !skid_v_ff;
   assign req_tready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) radius_ff <= RADIUS_RESET;
      else if (csr_wr_en) radius_ff <= csr_wr_data;
   end

   // ---------------------------------------------------- front: reduce angles
   logic signed [31:0] la1_s, lo1_s, la2_s, lo2_s;
   red_type            red_in [4];
   red_type            red_ff [4];

   always_comb begin
      la1_s = 32'(signed'(req_tdata[LAT1_LSB +: LAT_W]));
      lo1_s = 32'(signed'(req_tdata[LON1_LSB +: LON_W]));
      la2_s = 32'(signed'(req_tdata[LAT2_LSB +: LAT_W]));
      lo2_s = 32'(signed'(req_tdata[LON2_LSB +: LON_W]));
      // lanes: delta lat, delta lon, lat1, lat2 (all in half-microdegrees)
      red_in[0] = reduce_angle(la2_s - la1_s);
      red_in[1] = reduce_angle(lo2_s - lo1_s);
      red_in[2] = reduce_angle(la1_s <<< 1);
      red_in[3] = reduce_angle(la2_s <<< 1);
   end

   // degree-to-radian scaling, split into two partial products
   logic [MAG_W+28:0] pph_ff [4];
   logic [MAG_W+31:0] ppl_ff [4];
   logic [3:0]        msign1_ff, neg1_ff;
   logic signed [ROT_W-1:0] z0_ff [4];
   logic [3:0]        neg2_ff;
   logic [TW-1:0]     zsum [4];
   logic [ROT_W-1:0]  zmag [4];

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         zsum[l] = (TW'(pph_ff[l]) << 32) + TW'(ppl_ff[l]) + (TW'(1) << (CONV_SHIFT - 1));
         zmag[l] = ROT_W'(zsum[l] >> CONV_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int l = 0; l < 4; l++) begin
            red_ff[l]    <= red_in[l];
            pph_ff[l]    <= (MAG_W+29)'(red_ff[l].mag) * (MAG_W+29)'(CONV_HI);
            ppl_ff[l]    <= (MAG_W+32)'(red_ff[l].mag) * (MAG_W+32)'(CONV_LO);
            msign1_ff[l] <= red_ff[l].msign;
            neg1_ff[l]   <= red_ff[l].neg;
            z0_ff[l]     <= msign1_ff[l] ? -signed'(zmag[l]) : signed'(zmag[l]);
            neg2_ff[l]   <= neg1_ff[l];
         end
      end
   end

   // ---------------------------------------------------- rotation CORDIC row
   rot_type    rot_chain [N+1][4];
   logic [3:0] neg_dl_ff [N];

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         rot_chain[0][l].x = ROT_ONE;
         rot_chain[0][l].y = '0;
         rot_chain[0][l].z = z0_ff[l];
      end
   end

   for (genvar j = 0; j < N; j++) begin : g_rot
      for (genvar l = 0; l < 4; l++) begin : g_lane
         gcdist_rot_cell #(.STEP(j)) u_cell (
            .clock (clock),
            .en    (pipe_en),
            .din   (rot_chain[j][l]),
            .dout  (rot_chain[j+1][l])
         );
      end
   end

   // fold flags ride alongside the cells
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         neg_dl_ff[0] <= neg2_ff;
         for (int k = 1; k < N; k++) neg_dl_ff[k] <= neg_dl_ff[k-1];
      end
   end

   // ------------------------------------------------------ haversine products
   logic [ROT_W-1:0] s1m, s2m, c1m, c2m;
   logic             c1n, c2n;
   logic [PW-1:0]    p_s1, p_s2, p_cc;

   always_comb begin
      s1m = rot_chain[N][0].y[ROT_W-1] ? ROT_W'(-rot_chain[N][0].y)
                                        : ROT_W'(rot_chain[N][0].y);
      s2m = rot_chain[N][1].y[ROT_W-1] ? ROT_W'(-rot_chain[N][1].y)
                                        : ROT_W'(rot_chain[N][1].y);
      c1m = rot_chain[N][2].x[ROT_W-1] ? ROT_W'(-rot_chain[N][2].x)
                                        : ROT_W'(rot_chain[N][2].x);
      c2m = rot_chain[N][3].x[ROT_W-1] ? ROT_W'(-rot_chain[N][3].x)
                                        : ROT_W'(rot_chain[N][3].x);
      // sign of the folded cosine: negating flips the sign of a nonzero value
      c1n = neg_dl_ff[N-1][2] ? (rot_chain[N][2].x > 0) : (rot_chain[N][2].x < 0);
      c2n = neg_dl_ff[N-1][3] ? (rot_chain[N][3].x > 0) : (rot_chain[N][3].x < 0);
      p_s1 = PW'(s1m) * PW'(s1m);
      p_s2 = PW'(s2m) * PW'(s2m);
      p_cc = PW'(c1m) * PW'(c2m);
   end

   logic [ROT_W-1:0] sq1_ff, sq2_ff, ccm_ff;
   logic             ccn1_ff, ccn2_ff, ccn3_ff, ccn4_ff;
   logic [63:0]      g1h_ff, g2h_ff, gch_ff;
   logic [64:0]      g1l_ff, g2l_ff, gcl_ff;
   logic [ROT_W-1:0] t1_ff, t2_ff, ccg_ff, t1b_ff, prod_ff;
   logic [30:0]      a_ff;
   logic [PW-1:0]    p_ct;
   logic signed [ROT_W+1:0] a_s;

   function automatic logic [ROT_W-1:0] gain_fix(input logic [63:0] hi,
                                                 input logic [64:0] lo);
      logic [TW-1:0] s;
      s = (TW'(hi) << 31) + TW'(lo) + (TW'(1) << 61);
      return ROT_W'(s >> 62);
   endfunction

   always_comb begin
      p_ct = PW'(ccg_ff) * PW'(t2_ff);
      a_s  = ccn4_ff ? (signed'((ROT_W+2)'(t1b_ff)) - signed'((ROT_W+2)'(prod_ff)))
                     : (signed'((ROT_W+2)'(t1b_ff)) + signed'((ROT_W+2)'(prod_ff)));
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sq1_ff  <= ROT_W'((p_s1 + (PW'(1) << (ANGLE_FRAC_BITS - 1))) >> ANGLE_FRAC_BITS);
         sq2_ff  <= ROT_W'((p_s2 + (PW'(1) << (ANGLE_FRAC_BITS - 1))) >> ANGLE_FRAC_BITS);
         ccm_ff  <= ROT_W'((p_cc + (PW'(1) << (ANGLE_FRAC_BITS - 1))) >> ANGLE_FRAC_BITS);
         ccn1_ff <= c1n ^ c2n;
         // remove CORDIC gain squared: 61-bit factor in two halves
         g1h_ff  <= 64'(sq1_ff) * 64'(INV_HI);
         g1l_ff  <= 65'(sq1_ff) * 65'(INV_LO);
         g2h_ff  <= 64'(sq2_ff) * 64'(INV_HI);
         g2l_ff  <= 65'(sq2_ff) * 65'(INV_LO);
         gch_ff  <= 64'(ccm_ff) * 64'(INV_HI);
         gcl_ff  <= 65'(ccm_ff) * 65'(INV_LO);
         ccn2_ff <= ccn1_ff;
         t1_ff   <= gain_fix(g1h_ff, g1l_ff);
         t2_ff   <= gain_fix(g2h_ff, g2l_ff);
         ccg_ff  <= gain_fix(gch_ff, gcl_ff);
         ccn3_ff <= ccn2_ff;
         t1b_ff  <= t1_ff;
         prod_ff <= ROT_W'((p_ct + (PW'(1) << (ANGLE_FRAC_BITS - 1))) >> ANGLE_FRAC_BITS);
         ccn4_ff <= ccn3_ff;
         // a clamped to [0, 1]
         if (a_s < 0) a_ff <= '0;
         else if (a_s > signed'((ROT_W+2)'(A_ONE))) a_ff <= A_ONE;
         else a_ff <= 31'(a_s);
      end
   end

   // ------------------------------------------------------- square root rows
   sqrt_type sqa_chain [SQRT_STEPS+1];
   sqrt_type sqb_chain [SQRT_STEPS+1];

   always_comb begin
      sqa_chain[0].rem  = SQ_W'(a_ff) << (63 - ANGLE_FRAC_BITS);
      sqa_chain[0].root = '0;
      sqb_chain[0].rem  = SQ_W'(A_ONE - a_ff) << (63 - ANGLE_FRAC_BITS);
      sqb_chain[0].root = '0;
   end

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      gcdist_sqrt_cell #(.BIT(SQRT_STEPS - 1 - j)) u_cell_a (
         .clock (clock),
         .en    (pipe_en),
         .din   (sqa_chain[j]),
         .dout  (sqa_chain[j+1])
      );
      gcdist_sqrt_cell #(.BIT(SQRT_STEPS - 1 - j)) u_cell_b (
         .clock (clock),
         .en    (pipe_en),
         .din   (sqb_chain[j]),
         .dout  (sqb_chain[j+1])
      );
   end

   // ---------------------------------------------------- vectoring CORDIC row
   vec_type vec_chain [N+1];

   always_comb begin
      vec_chain[0].x = signed'(VEC_W'(sqb_chain[SQRT_STEPS].root) << VEC_SHIFT);
      vec_chain[0].y = signed'(VEC_W'(sqa_chain[SQRT_STEPS].root) << VEC_SHIFT);
      vec_chain[0].z = '0;
   end

   for (genvar j = 0; j < N; j++) begin : g_vec
      gcdist_vec_cell #(.STEP(j)) u_cell (
         .clock (clock),
         .en    (pipe_en),
         .din   (vec_chain[j]),
         .dout  (vec_chain[j+1])
      );
   end

   // ----------------------------------------------------------- scale to km
   logic signed [ZV_W:0]          ang_s;
   logic [ANGLE_W-1:0]            ang1_ff, ang2_ff, ang3_ff, ang4_ff;
   logic [RADIUS_W+ANGLE_W-1:0]   kmp_ff;
   logic [KM_W-1:0]               km3_ff, km4_ff;
   logic [MI_W-1:0]               mi_ff;
   logic [RADIUS_W+ANGLE_W-1:0]   km_r;
   logic [KM_W+3:0]               mi_r;

   always_comb begin
      ang_s = {vec_chain[N].z, 1'b0};
      km_r  = (kmp_ff + ((RADIUS_W+ANGLE_W)'(1) << (ANGLE_FRAC_BITS - 11)))
              >> (ANGLE_FRAC_BITS - 10);
      mi_r  = ((KM_W+4)'(km3_ff) * (KM_W+4)'(5) + (KM_W+4)'(4)) >> 3;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         if (ang_s < 0) ang1_ff <= '0;
         else if (ang_s > signed'({3'b000, PI_FIX})) ang1_ff <= PI_FIX;
         else ang1_ff <= ANGLE_W'(ang_s);
         ang2_ff <= ang1_ff;
         kmp_ff  <= (RADIUS_W+ANGLE_W)'(radius_ff) * (RADIUS_W+ANGLE_W)'(ang1_ff);
         ang3_ff <= ang2_ff;
         km3_ff  <= (km_r > (RADIUS_W+ANGLE_W)'({KM_W{1'b1}})) ? {KM_W{1'b1}}
                                                              : KM_W'(km_r);
         ang4_ff <= ang3_ff;
         km4_ff  <= km3_ff;
         mi_ff   <= (mi_r > (KM_W+4)'({MI_W{1'b1}})) ? {MI_W{1'b1}} : MI_W'(mi_r);
      end
   end

   assign pipe_data = {{RSP_PAD{1'b0}}, mi_ff, km4_ff, ang4_ff};

   // ------------------------------------------------ output register and skid
   assign pipe_out_v = vld_ff[LAT-1] && pipe_en;

   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (!out_v_ff || rsp_tready) begin
         if (skid_v_ff) begin
            out_v_in  = 1'b1;
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end else begin
            out_v_in = pipe_out_v;
            out_in   = pipe_data;
         end
      end else if (pipe_out_v) begin
         skid_v_in = 1'b1;
         skid_in   = pipe_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff;

   // ------------------------------------------------------------- assertions
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid holds a transfer while output register is empty");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[ANGLE_W-1:0] <= PI_FIX))
      else $error("central angle above pi");

   a_miles_le_km: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (KM_W'(rsp_tdata[MI_LSB +: MI_W]) <= rsp_tdata[KM_LSB +: KM_W]))
      else $error("miles exceed kilometers");

   a_freeze_on_full: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff && !rsp_tready |=> skid_v_ff && $stable(vld_ff))
      else $error("pipeline moved while skid was full");

endmodule
